// ===== hdl/hidx_pkg.sv =====
`timescale 1ns / 1ps
// hidx_pkg: request and result types, register indexes, fixed-point constants
// and reciprocal divide constants for the heat index pipeline.
// No dependencies.
package hidx_pkg;

  localparam int FRACTION_BITS = 24;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_MIN_TEMPERATURE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_HUMIDITY    = 1'b1;

  localparam logic signed [14:0] MIN_TEMPERATURE_RST = 15'sd2700;
  localparam logic [13:0]        MIN_HUMIDITY_RST    = 14'd4000;

  // temperature: floor(9t * 2^(q-2) / 125), split as 125*a + b
  localparam int T_DIV       = 125;
  localparam int T_BIAS      = 147500;
  localparam int TF_BIAS     = T_BIAS / T_DIV;
  localparam int XO_W        = 19;
  localparam int AT_W        = 12;
  localparam int PT_W        = 39;
  localparam int T_DIV_SHIFT = 26;
  localparam logic [19:0] T_DIV_MUL = 20'd536871;

  // humidity: floor(h * 2^(q-2) / 25), split as 25*a + b
  localparam int H_DIV       = 25;
  localparam int AH_W        = 10;
  localparam int PH_W        = 29;
  localparam int H_DIV_SHIFT = 19;
  localparam logic [14:0] H_DIV_MUL = 15'd20972;

  // back conversion: floor(m / 9) on a clamped, offset value
  localparam int R_DIV       = 9;
  localparam int MO_W        = 21;
  localparam int PR_W        = 43;
  localparam int R_DIV_SHIFT = 25;
  localparam logic [21:0] R_DIV_MUL = 22'd3728271;
  localparam int HI_LIMIT    = 100000;
  localparam int M_HI        = 900008;
  localparam int M_LO        = -900000;
  localparam int M_BIAS      = 900000;

  // regression coefficients, magnitudes in units of 1e-8
  localparam logic [63:0] DEC_SCALE = 64'd100000000;
  localparam logic [63:0] DEC_C0    = 64'd4237900000;
  localparam logic [63:0] DEC_C1    = 64'd204901523;
  localparam logic [63:0] DEC_C2    = 64'd1014333127;
  localparam logic [63:0] DEC_C3    = 64'd22475541;
  localparam logic [63:0] DEC_C4    = 64'd683783;
  localparam logic [63:0] DEC_C5    = 64'd5481717;
  localparam logic [63:0] DEC_C6    = 64'd122874;
  localparam logic [63:0] DEC_C7    = 64'd85282;
  localparam logic [63:0] DEC_C8    = 64'd199;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
  } request_t;

  typedef struct packed {
    logic signed [17:0] heat_index_centi;
    logic               index_valid;
  } result_t;

  function automatic logic [63:0] coef_mag(input logic [63:0] dec, input int q);
    return ((dec << q) + DEC_SCALE / 2) / DEC_SCALE;
  endfunction

endpackage

// ===== hdl/heat_index_regression.sv =====
`timescale 1ns / 1ps
// heat_index_regression: pipelined Rothfusz heat index in fixed point.
// Depends on hidx_pkg (types, register indexes, divide constants).
//
//   port group                 dir   handshake           payload
//   start / busy / request     in    start & !busy       hidx_pkg::request_t
//   done / result              out   done, one cycle     hidx_pkg::result_t
//   cfg_we / cfg_index / data  in    cfg_we              threshold registers
//
// one request per cycle; busy stays low
// each result shows on done in request order
// latency is set by the input divides, the multiplier chain of the degree-four
// term and the degF-to-degC divide, one multiplier of the chain per stage
// rst clears the pipeline valid bits and loads the threshold reset values
// the receiver cannot stall, so nothing ever waits inside the pipeline
module heat_index_regression #(
  parameter int FRACTION_BITS = hidx_pkg::FRACTION_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  hidx_pkg::request_t               request,
  output logic                             done,
  output hidx_pkg::result_t                result,
  input  logic                             cfg_we,
  input  logic [hidx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hidx_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int Q    = FRACTION_BITS;
  localparam int K    = Q - 2;
  localparam int TW   = Q + 10;
  localparam int RW   = Q + 9;
  localparam int CW   = Q + 5;
  localparam int SW   = Q + 18;
  localparam int NW   = SW + 10;
  localparam int MW   = NW - Q - 1;
  localparam int W1   = Q + 11;
  localparam int W2   = Q + 12;
  localparam int W3A  = Q + 8;
  localparam int W3   = Q + 15;
  localparam int W4A  = Q + 3;
  localparam int W4   = Q + 11;
  localparam int W5A  = Q + 5;
  localparam int W5   = Q + 12;
  localparam int W6A  = Q + 1;
  localparam int W6B  = Q + 9;
  localparam int W6   = Q + 16;
  localparam int W7A  = Q + 1;
  localparam int W7B  = Q + 7;
  localparam int W7   = Q + 14;
  localparam int W8A  = Q + 1;
  localparam int W8B  = Q + 1;
  localparam int W8C  = Q + 7;
  localparam int W8   = Q + 14;
  localparam int BT_W = $clog2(hidx_pkg::T_DIV);
  localparam int BH_W = $clog2(hidx_pkg::H_DIV);
  localparam int PIPE = 11;
  localparam int LATENCY = PIPE + 1;

  localparam logic signed [SW-1:0] C0 =
    SW'(64'd0 - hidx_pkg::coef_mag(hidx_pkg::DEC_C0, Q) - (64'd32 << Q));
  localparam logic signed [CW-1:0] C1 = CW'(hidx_pkg::coef_mag(hidx_pkg::DEC_C1, Q));
  localparam logic signed [CW-1:0] C2 = CW'(hidx_pkg::coef_mag(hidx_pkg::DEC_C2, Q));
  localparam logic signed [CW-1:0] C3 =
    CW'(64'd0 - hidx_pkg::coef_mag(hidx_pkg::DEC_C3, Q));
  localparam logic signed [CW-1:0] C4 =
    CW'(64'd0 - hidx_pkg::coef_mag(hidx_pkg::DEC_C4, Q));
  localparam logic signed [CW-1:0] C5 =
    CW'(64'd0 - hidx_pkg::coef_mag(hidx_pkg::DEC_C5, Q));
  localparam logic signed [CW-1:0] C6 = CW'(hidx_pkg::coef_mag(hidx_pkg::DEC_C6, Q));
  localparam logic signed [CW-1:0] C7 = CW'(hidx_pkg::coef_mag(hidx_pkg::DEC_C7, Q));
  localparam logic signed [CW-1:0] C8 =
    CW'(64'd0 - hidx_pkg::coef_mag(hidx_pkg::DEC_C8, Q));

  logic signed [14:0] min_temperature;
  logic [13:0]        min_humidity;

  logic [PIPE-1:0] vld;
  logic [PIPE-1:0] ok;

  // stage 0
  logic                             accept;
  logic                             ok0;
  logic signed [19:0]               xs0;
  logic [hidx_pkg::XO_W-1:0]        xo0;
  logic [hidx_pkg::PT_W-1:0]        pt0;
  logic [hidx_pkg::PH_W-1:0]        ph0;

  // stage 1
  logic [hidx_pkg::XO_W-1:0]        s1_xo;
  logic [hidx_pkg::PT_W-1:0]        s1_pt;
  logic [13:0]                      s1_h;
  logic [hidx_pkg::PH_W-1:0]        s1_ph;
  logic [hidx_pkg::AT_W-1:0]        at1;
  logic [BT_W-1:0]                  bt1;
  logic [hidx_pkg::AH_W-1:0]        ah1;
  logic [BH_W-1:0]                  bh1;

  // stage 2
  logic [hidx_pkg::AT_W-1:0]        s2_at;
  logic [BT_W-1:0]                  s2_bt;
  logic [hidx_pkg::AH_W-1:0]        s2_ah;
  logic [BH_W-1:0]                  s2_bh;
  logic [K-1:0]                     tab_t [hidx_pkg::T_DIV];
  logic [K-1:0]                     tab_h [hidx_pkg::H_DIV];
  logic signed [TW-1:0]             tf2;
  logic signed [RW-1:0]             rh2;

  // stage 3
  logic signed [TW-1:0]             s3_tf;
  logic signed [RW-1:0]             s3_rh;
  logic signed [CW+TW-1:0]          m_p1;
  logic signed [CW+RW-1:0]          m_p2;
  logic signed [CW+TW-1:0]          m_t3a;
  logic signed [CW+TW-1:0]          m_t4a;
  logic signed [CW+RW-1:0]          m_t5a;
  logic signed [CW+TW-1:0]          m_t6a;
  logic signed [CW+TW-1:0]          m_t7a;
  logic signed [CW+TW-1:0]          m_t8a;

  // stage 4
  logic signed [TW-1:0]             s4_tf;
  logic signed [RW-1:0]             s4_rh;
  logic signed [W1-1:0]             s4_p1;
  logic signed [W2-1:0]             s4_p2;
  logic signed [W3A-1:0]            s4_t3a;
  logic signed [W4A-1:0]            s4_t4a;
  logic signed [W5A-1:0]            s4_t5a;
  logic signed [W6A-1:0]            s4_t6a;
  logic signed [W7A-1:0]            s4_t7a;
  logic signed [W8A-1:0]            s4_t8a;
  logic signed [W3A+RW-1:0]         m_t3;
  logic signed [W4A+TW-1:0]         m_t4;
  logic signed [W5A+RW-1:0]         m_t5;
  logic signed [W6A+TW-1:0]         m_t6b;
  logic signed [W7A+RW-1:0]         m_t7b;
  logic signed [W8A+TW-1:0]         m_t8b;

  // stage 5
  logic signed [RW-1:0]             s5_rh;
  logic signed [W1-1:0]             s5_p1;
  logic signed [W2-1:0]             s5_p2;
  logic signed [W3-1:0]             s5_t3;
  logic signed [W4-1:0]             s5_t4;
  logic signed [W5-1:0]             s5_t5;
  logic signed [W6B-1:0]            s5_t6b;
  logic signed [W7B-1:0]            s5_t7b;
  logic signed [W8B-1:0]            s5_t8b;
  logic signed [W6B+RW-1:0]         m_t6;
  logic signed [W7B+RW-1:0]         m_t7;
  logic signed [W8B+RW-1:0]         m_t8c;
  logic signed [SW-1:0]             sa5;
  logic signed [SW-1:0]             sb5;

  // stage 6
  logic signed [RW-1:0]             s6_rh;
  logic signed [W6-1:0]             s6_t6;
  logic signed [W7-1:0]             s6_t7;
  logic signed [W8C-1:0]            s6_t8c;
  logic signed [SW-1:0]             s6_sa;
  logic signed [SW-1:0]             s6_sb;
  logic signed [W8C+RW-1:0]         m_t8;

  // stage 7
  logic signed [W8-1:0]             s7_t8;
  logic signed [SW-1:0]             s7_sc;
  logic signed [SW-1:0]             s7_sd;

  // stage 8
  logic signed [SW-1:0]             s8_d;
  logic signed [NW-1:0]             n8;

  // stage 9
  logic signed [MW-1:0]             s9_m;
  logic signed [MW-1:0]             mc9;
  logic [hidx_pkg::MO_W-1:0]        mo9;

  // stage 10
  logic [hidx_pkg::MO_W-1:0]        s10_mo;
  logic [hidx_pkg::PR_W-1:0]        pr10;

  // stage 11
  logic [hidx_pkg::PR_W-1:0]        s11_pr;
  logic [17:0]                      q11;
  logic signed [17:0]               res11;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_temperature <= hidx_pkg::MIN_TEMPERATURE_RST;
      min_humidity    <= hidx_pkg::MIN_HUMIDITY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hidx_pkg::REG_MIN_TEMPERATURE: min_temperature <= $signed(cfg_data[14:0]);
        hidx_pkg::REG_MIN_HUMIDITY:    min_humidity    <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[PIPE-2:0], accept};
      done <= vld[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    ok <= {ok[PIPE-2:0], ok0};
  end

  // stage 0: thresholds, offset 9t, reciprocal products
  assign ok0 = (request.temperature_centi >= min_temperature) &&
               (request.humidity_centi >= min_humidity);
  assign xs0 = (20'(request.temperature_centi) <<< 3) + 20'(request.temperature_centi)
             + 20'(hidx_pkg::T_BIAS);
  assign xo0 = xs0[hidx_pkg::XO_W-1:0];
  assign pt0 = hidx_pkg::PT_W'(xo0) * hidx_pkg::PT_W'(hidx_pkg::T_DIV_MUL);
  assign ph0 = hidx_pkg::PH_W'(request.humidity_centi) * hidx_pkg::PH_W'(hidx_pkg::H_DIV_MUL);

  always_ff @(posedge clk) begin
    s1_xo <= xo0;
    s1_pt <= pt0;
    s1_h  <= request.humidity_centi;
    s1_ph <= ph0;
  end

  // stage 1: quotient and remainder
  assign at1 = s1_pt[hidx_pkg::T_DIV_SHIFT+hidx_pkg::AT_W-1:hidx_pkg::T_DIV_SHIFT];
  assign bt1 = BT_W'(s1_xo - hidx_pkg::XO_W'(at1) * hidx_pkg::XO_W'(hidx_pkg::T_DIV));
  assign ah1 = s1_ph[hidx_pkg::H_DIV_SHIFT+hidx_pkg::AH_W-1:hidx_pkg::H_DIV_SHIFT];
  assign bh1 = BH_W'(s1_h - 14'(ah1) * 14'(hidx_pkg::H_DIV));

  always_ff @(posedge clk) begin
    s2_at <= at1;
    s2_bt <= bt1;
    s2_ah <= ah1;
    s2_bh <= bh1;
  end

  // stage 2: fractional remainder tables, tf in degF and rh
  for (genvar gi = 0; gi < hidx_pkg::T_DIV; gi++) begin : g_tab_t
    localparam logic [63:0] TV = (64'(gi) << K) / 64'(hidx_pkg::T_DIV);
    assign tab_t[gi] = TV[K-1:0];
  end

  for (genvar gj = 0; gj < hidx_pkg::H_DIV; gj++) begin : g_tab_h
    localparam logic [63:0] HV = (64'(gj) << K) / 64'(hidx_pkg::H_DIV);
    assign tab_h[gj] = HV[K-1:0];
  end

  assign tf2 = ((TW'($signed({1'b0, s2_at})) - TW'(hidx_pkg::TF_BIAS)) <<< K)
             + TW'({1'b0, tab_t[s2_bt]}) + (TW'(32) <<< Q);
  assign rh2 = (RW'({1'b0, s2_ah}) <<< K) + RW'({1'b0, tab_h[s2_bh]});

  always_ff @(posedge clk) begin
    s3_tf <= tf2;
    s3_rh <= rh2;
  end

  // stage 3: coefficient products
  assign m_p1  = C1 * s3_tf;
  assign m_p2  = C2 * s3_rh;
  assign m_t3a = C3 * s3_tf;
  assign m_t4a = C4 * s3_tf;
  assign m_t5a = C5 * s3_rh;
  assign m_t6a = C6 * s3_tf;
  assign m_t7a = C7 * s3_tf;
  assign m_t8a = C8 * s3_tf;

  always_ff @(posedge clk) begin
    s4_tf  <= s3_tf;
    s4_rh  <= s3_rh;
    s4_p1  <= m_p1[Q+W1-1:Q];
    s4_p2  <= m_p2[Q+W2-1:Q];
    s4_t3a <= m_t3a[Q+W3A-1:Q];
    s4_t4a <= m_t4a[Q+W4A-1:Q];
    s4_t5a <= m_t5a[Q+W5A-1:Q];
    s4_t6a <= m_t6a[Q+W6A-1:Q];
    s4_t7a <= m_t7a[Q+W7A-1:Q];
    s4_t8a <= m_t8a[Q+W8A-1:Q];
  end

  // stage 4: second factor
  assign m_t3  = s4_t3a * s4_rh;
  assign m_t4  = s4_t4a * s4_tf;
  assign m_t5  = s4_t5a * s4_rh;
  assign m_t6b = s4_t6a * s4_tf;
  assign m_t7b = s4_t7a * s4_rh;
  assign m_t8b = s4_t8a * s4_tf;

  always_ff @(posedge clk) begin
    s5_rh  <= s4_rh;
    s5_p1  <= s4_p1;
    s5_p2  <= s4_p2;
    s5_t3  <= m_t3[Q+W3-1:Q];
    s5_t4  <= m_t4[Q+W4-1:Q];
    s5_t5  <= m_t5[Q+W5-1:Q];
    s5_t6b <= m_t6b[Q+W6B-1:Q];
    s5_t7b <= m_t7b[Q+W7B-1:Q];
    s5_t8b <= m_t8b[Q+W8B-1:Q];
  end

  // stage 5: third factor, first partial sums (intercept includes the -32 degF)
  assign m_t6  = s5_t6b * s5_rh;
  assign m_t7  = s5_t7b * s5_rh;
  assign m_t8c = s5_t8b * s5_rh;
  assign sa5   = C0 + SW'(s5_p1) + SW'(s5_p2);
  assign sb5   = SW'(s5_t3) + SW'(s5_t4) + SW'(s5_t5);

  always_ff @(posedge clk) begin
    s6_rh  <= s5_rh;
    s6_t6  <= m_t6[Q+W6-1:Q];
    s6_t7  <= m_t7[Q+W7-1:Q];
    s6_t8c <= m_t8c[Q+W8C-1:Q];
    s6_sa  <= sa5;
    s6_sb  <= sb5;
  end

  // stage 6: last factor of the degree-four term
  assign m_t8 = s6_t8c * s6_rh;

  always_ff @(posedge clk) begin
    s7_t8 <= m_t8[Q+W8-1:Q];
    s7_sc <= s6_sa + s6_sb;
    s7_sd <= SW'(s6_t6) + SW'(s6_t7);
  end

  // stage 7: sum minus 32 degF
  always_ff @(posedge clk) begin
    s8_d <= s7_sc + s7_sd + SW'(s7_t8);
  end

  // stage 8: d * 1000 + 9 * 2^q, floor by 2^(q+1)
  assign n8 = (NW'(s8_d) <<< 10) - (NW'(s8_d) <<< 4) - (NW'(s8_d) <<< 3)
            + (NW'(hidx_pkg::R_DIV) <<< Q);

  always_ff @(posedge clk) begin
    s9_m <= n8[NW-1:Q+1];
  end

  // stage 9: clamp so floor(m / 9) lands in range, then offset
  always_comb begin
    if (s9_m > MW'(hidx_pkg::M_HI)) begin
      mc9 = MW'(hidx_pkg::M_HI);
    end else if (s9_m < MW'(hidx_pkg::M_LO)) begin
      mc9 = MW'(hidx_pkg::M_LO);
    end else begin
      mc9 = s9_m;
    end
  end

  assign mo9 = hidx_pkg::MO_W'(mc9 + MW'(hidx_pkg::M_BIAS));

  always_ff @(posedge clk) begin
    s10_mo <= mo9;
  end

  // stage 10: reciprocal of 9
  assign pr10 = hidx_pkg::PR_W'(s10_mo) * hidx_pkg::PR_W'(hidx_pkg::R_DIV_MUL);

  always_ff @(posedge clk) begin
    s11_pr <= pr10;
  end

  // stage 11: remove offset, output register
  assign q11   = s11_pr[hidx_pkg::PR_W-1:hidx_pkg::R_DIV_SHIFT];
  assign res11 = $signed(q11 - 18'(hidx_pkg::HI_LIMIT));

  always_ff @(posedge clk) begin
    result.heat_index_centi <= ok[PIPE-1] ? res11 : '0;
    result.index_valid      <= ok[PIPE-1];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("request did not produce a result at the expected latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without a matching request");

  a_below_threshold: assert property (@(posedge clk) disable iff (rst)
    accept && ((request.temperature_centi < min_temperature) ||
               (request.humidity_centi < min_humidity))
    |-> ##LATENCY (done && !result.index_valid && result.heat_index_centi == '0))
    else $error("below-threshold request gave a valid result");

  a_saturation: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.heat_index_centi <= 18'sd100000 &&
              result.heat_index_centi >= -18'sd100000))
    else $error("heat index outside the saturation limits");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for heat_index_regression, directed table then random requests
// under several threshold settings, each result checked against a fixed-point heat index predictor.
// Depends on hidx_pkg (request/result types, register indexes) and the heat_index_regression RTL.
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_REQUESTS = 256;
  localparam int RANDOM_PHASES = 6;
  localparam int TAIL_CYCLES = 20;
  localparam int CLAMP = 100000;

  typedef enum {ROW_CFG, ROW_PREDICT, ROW_BELOW, ROW_CLAMP_HI} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int        a;
    int        b;
  } row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             start = 1'b0;
  logic                             busy;
  hidx_pkg::request_t               request = '0;
  logic                             done;
  hidx_pkg::result_t                result;
  logic                             cfg_we = 1'b0;
  logic [hidx_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [hidx_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  hidx_pkg::result_t pending_heat_index[$];
  hidx_pkg::result_t oldest;
  longint  min_temp_reg = longint'(hidx_pkg::MIN_TEMPERATURE_RST);
  longint  min_hum_reg = longint'(hidx_pkg::MIN_HUMIDITY_RST);
  bit      steady_feed = 1'b0;
  int      mismatch_count = 0;
  int      sent_count = 0;
  int      settings_count = 0;
  int      valid_count = 0;
  int      below_count = 0;
  int      clamp_count = 0;
  int      cycle_count = 0;

  // a: temperature or register index, b: humidity or register value
  row_t directed_rows [0:28] = '{
    '{ROW_BELOW, 2699, 5000},
    '{ROW_BELOW, 3000, 3999},
    '{ROW_PREDICT, 2700, 4000},
    '{ROW_PREDICT, 8500, 10000},
    '{ROW_BELOW, -4000, 0},
    '{ROW_CLAMP_HI, 16383, 16383},
    '{ROW_CFG, int'(hidx_pkg::REG_MIN_TEMPERATURE), -16384},
    '{ROW_CFG, int'(hidx_pkg::REG_MIN_HUMIDITY), 0},
    '{ROW_PREDICT, -16384, 0},
    '{ROW_PREDICT, -16384, 16383},
    '{ROW_PREDICT, 16383, 0},
    '{ROW_PREDICT, -4000, 10000},
    '{ROW_PREDICT, 0, 0},
    '{ROW_PREDICT, -1, 5000},
    '{ROW_CFG, int'(hidx_pkg::REG_MIN_TEMPERATURE), 16383},
    '{ROW_CFG, int'(hidx_pkg::REG_MIN_HUMIDITY), 16383},
    '{ROW_BELOW, 16382, 16383},
    '{ROW_BELOW, 16383, 16382},
    '{ROW_CLAMP_HI, 16383, 16383},
    '{ROW_CFG, int'(hidx_pkg::REG_MIN_TEMPERATURE), 8500},
    '{ROW_CFG, int'(hidx_pkg::REG_MIN_HUMIDITY), 10000},
    '{ROW_BELOW, 8499, 10000},
    '{ROW_PREDICT, 8500, 10000},
    '{ROW_BELOW, 8500, 9999},
    '{ROW_CFG, int'(hidx_pkg::REG_MIN_TEMPERATURE), -4000},
    '{ROW_CFG, int'(hidx_pkg::REG_MIN_HUMIDITY), 0},
    '{ROW_BELOW, -4001, 5000},
    '{ROW_PREDICT, -4000, 0},
    '{ROW_PREDICT, 3500, 6000}
  };

  heat_index_regression dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint floor_div(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] p;
    wa = 128'(a);
    wb = 128'(b);
    p = (wa * wb) >>> hidx_pkg::FRACTION_BITS;
    return p[63:0];
  endfunction

  // magnitude in units of 1e-8, rounded to the nearest fixed-point step
  function automatic longint regression_coef(input longint unsigned mag, input bit negative);
    longint unsigned m;
    m = (mag * (64'd1 << hidx_pkg::FRACTION_BITS) + 64'd50000000) / 64'd100000000;
    return negative ? -longint'(m) : longint'(m);
  endfunction

  function automatic hidx_pkg::result_t rothfusz_heat_index(input logic signed [14:0] temp,
                                                            input logic [13:0] hum);
    longint            one;
    longint            tv;
    longint            hv;
    longint            tf;
    longint            rh;
    longint            acc;
    longint            hi;
    hidx_pkg::result_t r;
    one = longint'(1) << hidx_pkg::FRACTION_BITS;
    tv = longint'(temp);
    hv = longint'(hum);
    r = '0;
    if (tv < min_temp_reg || hv < min_hum_reg) return r;
    tf = floor_div(tv * 9 * one, 500) + 32 * one;
    rh = floor_div(hv * one, 100);
    acc = regression_coef(64'd4237900000, 1'b1);
    acc += fx_mul(regression_coef(64'd204901523, 1'b0), tf);
    acc += fx_mul(regression_coef(64'd1014333127, 1'b0), rh);
    acc += fx_mul(fx_mul(regression_coef(64'd22475541, 1'b1), tf), rh);
    acc += fx_mul(fx_mul(regression_coef(64'd683783, 1'b1), tf), tf);
    acc += fx_mul(fx_mul(regression_coef(64'd5481717, 1'b1), rh), rh);
    acc += fx_mul(fx_mul(fx_mul(regression_coef(64'd122874, 1'b0), tf), tf), rh);
    acc += fx_mul(fx_mul(fx_mul(regression_coef(64'd85282, 1'b0), tf), rh), rh);
    acc += fx_mul(fx_mul(fx_mul(fx_mul(regression_coef(64'd199, 1'b1), tf), tf), rh), rh);
    // degF back to centi-degC, ties toward plus infinity
    hi = floor_div((acc - 32 * one) * 1000 + 9 * one, 18 * one);
    if (hi > CLAMP) hi = CLAMP;
    if (hi < -CLAMP) hi = -CLAMP;
    r.heat_index_centi = hi[17:0];
    r.index_valid = 1'b1;
    return r;
  endfunction

  task automatic feed_request(input logic signed [14:0] temp, input logic [13:0] hum,
                              input hidx_pkg::result_t want);
    while (!steady_feed && $urandom_range(99) < 17) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    request <= '{temperature_centi: temp, humidity_centi: hum};
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_heat_index.push_back(want);
    sent_count++;
  endtask

  // thresholds change only with the pipeline drained
  task automatic write_threshold(input logic [hidx_pkg::CFG_INDEX_W-1:0] idx,
                                 input logic [hidx_pkg::CFG_DATA_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_heat_index.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hidx_pkg::REG_MIN_TEMPERATURE) min_temp_reg = longint'($signed(value));
    else min_hum_reg = longint'(value[13:0]);
    settings_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_heat_index.size() == 0) begin
        $error("result with no request outstanding: heat_index_centi %0d index_valid %0d",
               $signed(result.heat_index_centi), result.index_valid);
        mismatch_count++;
      end else begin
        oldest = pending_heat_index.pop_front();
        if (result.heat_index_centi !== oldest.heat_index_centi) begin
          $error("heat_index_centi mismatch: expected %0d, got %0d",
                 $signed(oldest.heat_index_centi), $signed(result.heat_index_centi));
          mismatch_count++;
        end
        if (result.index_valid !== oldest.index_valid) begin
          $error("index_valid mismatch: expected %0d, got %0d",
                 oldest.index_valid, result.index_valid);
          mismatch_count++;
        end
        if (oldest.index_valid) valid_count++;
        else below_count++;
        if ($signed(oldest.heat_index_centi) == CLAMP ||
            $signed(oldest.heat_index_centi) == -CLAMP) clamp_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("heat_index_regression verification failed");
      $finish;
    end
  end

  initial begin
    hidx_pkg::result_t  want;
    logic signed [14:0] t;
    logic [13:0]        h;
    int                 pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          write_threshold(hidx_pkg::CFG_INDEX_W'(directed_rows[i].a),
                          hidx_pkg::CFG_DATA_W'(directed_rows[i].b));
        end
        ROW_BELOW: begin
          want = '0;
          feed_request(15'(directed_rows[i].a), 14'(directed_rows[i].b), want);
        end
        ROW_CLAMP_HI: begin
          want = '{heat_index_centi: 18'(CLAMP), index_valid: 1'b1};
          feed_request(15'(directed_rows[i].a), 14'(directed_rows[i].b), want);
        end
        default: begin
          t = 15'(directed_rows[i].a);
          h = 14'(directed_rows[i].b);
          feed_request(t, h, rothfusz_heat_index(t, h));
        end
      endcase
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_threshold(hidx_pkg::REG_MIN_TEMPERATURE, hidx_pkg::MIN_TEMPERATURE_RST);
          write_threshold(hidx_pkg::REG_MIN_HUMIDITY, {1'b0, hidx_pkg::MIN_HUMIDITY_RST});
        end
        1: begin
          // unused top bit of the humidity write must be dropped
          write_threshold(hidx_pkg::REG_MIN_TEMPERATURE, 15'h4000);
          write_threshold(hidx_pkg::REG_MIN_HUMIDITY, {1'b1, 14'd0});
        end
        default: begin
          t = 15'(int'($urandom_range(12500)) - 4000);
          write_threshold(hidx_pkg::REG_MIN_TEMPERATURE, t);
          h = 14'($urandom_range(10000));
          write_threshold(hidx_pkg::REG_MIN_HUMIDITY, {1'($urandom_range(1)), h});
        end
      endcase
      steady_feed = (phase == 2);
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        pick = int'($urandom_range(99));
        if (pick < 60) begin
          t = 15'(int'($urandom_range(12500)) - 4000);
          h = 14'($urandom_range(10000));
        end else if (pick < 80) begin
          // straddle the thresholds
          t = 15'(min_temp_reg + longint'($urandom_range(6)) - 3);
          h = 14'(min_hum_reg + longint'($urandom_range(6)) - 3);
        end else begin
          t = 15'($urandom_range(32767));
          h = 14'($urandom_range(16383));
        end
        feed_request(t, h, rothfusz_heat_index(t, h));
      end
    end
    steady_feed = 1'b0;
    start <= 1'b0;

    while (pending_heat_index.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d requests under %0d threshold writes", sent_count, settings_count);
    $display("results: %0d valid, %0d below threshold, %0d at the clamp limit",
             valid_count, below_count, clamp_count);
    if (mismatch_count == 0) begin
      $display("heat_index_regression verification clean");
    end else begin
      $display("heat_index_regression verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hidx_pkg.sv
hdl/heat_index_regression.sv
sim/testbench.sv
